// File: hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: hw/rtl/kqs_pkg.sv
package kqs_pkg;

  localparam int CAPACITY   = 16;
  localparam int NUM_QUEUES = 4;
  localparam int DATA_WIDTH = 32;

  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  localparam int OP_W  = 2;
  localparam int QI_W  = 2;
  localparam int XD_W  = 32;
  localparam int ST_W  = 2;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  localparam slot_t NULL_SLOT = SLOT_W'(CAPACITY);

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } link_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } link_wr_t;

  function automatic logic is_slot(input slot_t s);
    return s < NULL_SLOT;
  endfunction

  function automatic word_t to_store(input logic [XD_W-1:0] v);
    logic signed [63:0] e;
    e = 64'(signed'(v));
    return e[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [XD_W-1:0] to_out(input word_t v);
    logic signed [63:0] e;
    e = 64'(signed'(v));
    return e[XD_W-1:0];
  endfunction

endpackage

// File: hw/rtl/kqs_in_if.sv
interface kqs_in_if import kqs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        operation;
  logic [QI_W-1:0]        queue_index;
  logic signed [XD_W-1:0] data_in;

  modport source (output valid, operation, queue_index, data_in, input ready);
  modport sink   (input valid, operation, queue_index, data_in, output ready);
endinterface

// File: hw/rtl/kqs_out_if.sv
interface kqs_out_if import kqs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [XD_W-1:0] data_out;
  logic [ST_W-1:0]        status;
  logic                   queue_now_empty;
  logic                   store_now_full;

  modport source (output valid, data_out, status, queue_now_empty, store_now_full,
                  input ready);
  modport sink   (input valid, data_out, status, queue_now_empty, store_now_full,
                  output ready);
endinterface

// File: hw/rtl/kqs_ram.sv
module kqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/kqs_link_mem.sv
module kqs_link_mem import kqs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  link_rd_t rd_i,
  input  link_wr_t wr_i,
  output slot_t    rdata_o
);

  slot_t               mem [CAPACITY];
  logic [CAPACITY-1:0] vld_q;
  slot_t               mem_rd_q;
  slot_t               dflt_q;
  logic                hit_q;

  // unwritten entries read as the reset chain: slot i links to i+1
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      mem_rd_q <= mem[rd_i.addr];
      dflt_q   <= SLOT_W'(rd_i.addr) + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        hit_q <= vld_q[rd_i.addr];
      end
    end
  end

  assign rdata_o = hit_q ? mem_rd_q : dflt_q;

endmodule

// File: hw/rtl/k_queues_shared_store.sv
// Shared-store multi-queue: NUM_QUEUES FIFO queues as linked lists over one
// store of CAPACITY slots, unused slots on a common free list.
// in_i  : request channel (operation, queue_index, data_in), valid/ready.
//         Operations: enqueue, dequeue (returns removed value), peek at head.
// out_o : one result per request (data_out, status, queue_now_empty,
//         store_now_full), held in an output register.
// Timing: a request is taken only in the idle state; on that edge the link
//         and data memories are read. Once the output register is free, the
//         update state sets head/tail/free pointers, writes back at most one
//         link and at most one data word, and loads the result register,
//         which raises out_o.valid. A new request is taken only after the
//         update of the previous one is done.
// Stall: while a previous result waits in the output register a new request
//         is still taken; its update waits until the register frees.
// Reset: all queues empty, free list links every slot in order (per-slot
//         valid bits on the link memory, no clearing pass); usable at once.
`include "assert_macros.svh"

module k_queues_shared_store import kqs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  kqs_in_if.sink   in_i,
  kqs_out_if.source out_o
);

  state_e state_q, state_d;

  logic [OP_W-1:0] op_q;
  logic [QI_W-1:0] qi_q;
  logic [XD_W-1:0] din_q;

  slot_t head_q [NUM_QUEUES];
  slot_t head_d [NUM_QUEUES];
  slot_t tail_q [NUM_QUEUES];
  slot_t tail_d [NUM_QUEUES];
  slot_t free_head_q, free_head_d;

  logic            out_vld_q;
  logic [XD_W-1:0] res_data_q, res_data_d;
  status_e         res_st_q, res_st_d;
  logic            res_qe_q, res_qe_d;
  logic            res_sf_q, res_sf_d;

  logic in_fire, exec_en, exec_fire, out_free;
  logic enq_done, deq_done;

  logic [QIDX_W-1:0] q_in, q;
  logic              q_ok;
  slot_t             h_in, h, t;

  link_rd_t link_rd;
  link_wr_t link_wr;
  slot_t    link_rdata;
  word_t    data_rdata;
  logic     data_we;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    exec_en    = 1'b0;
    unique case (state_q)
      S_IDLE:  in_i.ready = 1'b1;
      S_EXEC:  exec_en    = 1'b1;
      default: ;
    endcase
  end

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_free  = !out_vld_q || out_o.ready;
  assign exec_fire = exec_en && out_free;

  // ------------------------------------------------------------ read issue
  assign q_in = QIDX_W'(in_i.queue_index);
  assign h_in = head_q[q_in];

  always_comb begin
    link_rd.en   = in_fire;
    link_rd.addr = (op_e'(in_i.operation) == OP_ENQ) ? free_head_q[IDX_W-1:0]
                                                      : h_in[IDX_W-1:0];
  end

  // ---------------------------------------------------------- update step
  assign q    = QIDX_W'(qi_q);
  assign q_ok = 32'(qi_q) < NUM_QUEUES;
  assign h    = head_q[q];
  assign t    = tail_q[q];

  always_comb begin
    slot_t nx;
    head_d      = head_q;
    tail_d      = tail_q;
    free_head_d = free_head_q;
    link_wr     = '0;
    data_we     = 1'b0;
    res_data_d  = '0;
    res_st_d    = ST_DONE;
    res_qe_d    = 1'b1;
    enq_done    = 1'b0;
    deq_done    = 1'b0;
    nx          = link_rdata;
    if (q_ok) begin
      case (op_e'(op_q))
        OP_ENQ: begin
          if (!is_slot(free_head_q)) begin
            res_st_d = ST_FULL;
          end else begin
            enq_done    = 1'b1;
            free_head_d = is_slot(nx) ? nx : NULL_SLOT;
            if (!is_slot(h)) begin
              head_d[q] = free_head_q;
            end else if (is_slot(t)) begin
              link_wr.en   = 1'b1;
              link_wr.addr = t[IDX_W-1:0];
              link_wr.data = free_head_q;
            end
            tail_d[q] = free_head_q;
            data_we   = 1'b1;
          end
        end
        OP_DEQ: begin
          if (!is_slot(h)) begin
            res_st_d = ST_EMPTY;
          end else begin
            // the tail's successor is null whatever its link holds
            deq_done     = 1'b1;
            res_data_d   = to_out(data_rdata);
            head_d[q]    = (h == t || !is_slot(nx)) ? NULL_SLOT : nx;
            link_wr.en   = 1'b1;
            link_wr.addr = h[IDX_W-1:0];
            link_wr.data = free_head_q;
            free_head_d  = h;
          end
        end
        OP_PEEK: begin
          if (!is_slot(h)) begin
            res_st_d = ST_EMPTY;
          end else begin
            res_data_d = to_out(data_rdata);
          end
        end
        default: ;
      endcase
      res_qe_d = !is_slot(head_d[q]);
    end else begin
      res_st_d = ST_EMPTY;
    end
    res_sf_d   = !is_slot(free_head_d);
    link_wr.en = link_wr.en && exec_fire;
    data_we    = data_we && exec_fire;
    enq_done   = enq_done && exec_fire;
    deq_done   = deq_done && exec_fire;
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      out_vld_q   <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= NULL_SLOT;
      end
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        free_head_q <= free_head_d;
        head_q      <= head_d;
        out_vld_q   <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_i.operation;
      qi_q  <= in_i.queue_index;
      din_q <= in_i.data_in;
    end
    if (exec_fire) begin
      tail_q     <= tail_d;
      res_data_q <= res_data_d;
      res_st_q   <= res_st_d;
      res_qe_q   <= res_qe_d;
      res_sf_q   <= res_sf_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.data_out        = res_data_q;
  assign out_o.status          = res_st_q;
  assign out_o.queue_now_empty = res_qe_q;
  assign out_o.store_now_full  = res_sf_q;

  // ------------------------------------------------------------- memories
  kqs_link_mem u_link (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (link_rd),
    .wr_i    (link_wr),
    .rdata_o (link_rdata)
  );

  kqs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_data (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (free_head_q[IDX_W-1:0]),
    .wdata_i (to_store(din_q)),
    .re_i    (in_fire),
    .raddr_i (h_in[IDX_W-1:0]),
    .rdata_o (data_rdata)
  );

  // ----------------------------------------------------------- assertions
  `ASSERT_CLK(a_one_in_flight, in_fire |=> !in_i.ready, "request taken during update")
  `ASSERT_CLK(a_enq_pops_free, enq_done |=> free_head_q != $past(free_head_q), "free head held")
  `ASSERT_CLK(a_deq_pushes_free, deq_done |=> free_head_q == $past(h), "dequeued slot not freed")
  `ASSERT_NEVER(a_free_head_range, free_head_q > NULL_SLOT, "free head out of range")

endmodule

// File: sim/k_queues_shared_store_tb.sv
`timescale 1ns / 1ps

module k_queues_shared_store_tb;
  import kqs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [XD_W-1:0] data;
    logic [ST_W-1:0] status;
    logic            qe;
    logic            sf;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [QI_W-1:0] qi;
    logic [XD_W-1:0] data;
    logic            pinned;
    result_t         want;
  } req_row_t;

  logic clk_i;
  logic rst_ni;

  kqs_in_if  in_if ();
  kqs_out_if out_if ();

  k_queues_shared_store uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow of the shared store
  word_t mem_data [CAPACITY];
  slot_t mem_link [CAPACITY];
  slot_t q_head   [NUM_QUEUES];
  slot_t q_tail   [NUM_QUEUES];
  slot_t free_ptr;
  int    slots_used;
  int    peak_used;

  result_t  awaited_results[$];
  req_row_t directed_rows[$];

  // typed-in expectation travels with the request
  logic    pin_flag;
  result_t pin_want;

  int burst_left;
  int n_sent;
  int n_directed;
  int n_checked;
  int n_full;
  int n_empty;
  int n_errors;
  int cycles;

  function automatic void reset_store();
    for (int i = 0; i < CAPACITY; i++) begin
      mem_data[i] = '0;
      mem_link[i] = slot_t'(i + 1);
    end
    for (int i = 0; i < NUM_QUEUES; i++) begin
      q_head[i] = NULL_SLOT;
      q_tail[i] = NULL_SLOT;
    end
    free_ptr   = '0;
    slots_used = 0;
    peak_used  = 0;
  endfunction

  function automatic result_t queue_store_update(input logic [OP_W-1:0] op,
                                                 input logic [QI_W-1:0] qi,
                                                 input logic [XD_W-1:0] d);
    result_t                       r;
    slot_t                         s;
    slot_t                         nx;
    slot_t                         h;
    logic signed [XD_W-1:0]        sd;
    logic signed [DATA_WIDTH-1:0]  sw;
    int                            q;
    r        = '0;
    r.status = ST_DONE;
    r.qe     = 1'b1;
    q        = int'(qi);
    if (q < NUM_QUEUES) begin
      h = q_head[q];
      if (op == OP_ENQ) begin
        s = free_ptr;
        if (s >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          nx       = mem_link[s];
          free_ptr = (nx < CAPACITY) ? nx : NULL_SLOT;
          if (h >= CAPACITY) begin
            q_head[q] = s;
          end else if (q_tail[q] < CAPACITY) begin
            mem_link[q_tail[q]] = s;
          end
          mem_link[s] = NULL_SLOT;
          q_tail[q]   = s;
          sd          = d;
          mem_data[s] = DATA_WIDTH'(sd);
          slots_used++;
          if (slots_used > peak_used) peak_used = slots_used;
        end
      end else if (op == OP_DEQ) begin
        if (h >= CAPACITY) begin
          r.status = ST_EMPTY;
        end else begin
          nx          = mem_link[h];
          sw          = mem_data[h];
          r.data      = XD_W'(sw);
          q_head[q]   = (nx < CAPACITY) ? nx : NULL_SLOT;
          mem_link[h] = free_ptr;
          free_ptr    = h;
          slots_used--;
        end
      end else if (op == OP_PEEK) begin
        if (h >= CAPACITY) begin
          r.status = ST_EMPTY;
        end else begin
          sw     = mem_data[h];
          r.data = XD_W'(sw);
        end
      end
      r.qe = (q_head[q] >= CAPACITY);
    end else begin
      r.status = ST_EMPTY;
    end
    r.sf = (free_ptr >= CAPACITY);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [QI_W-1:0] qi,
                         input logic [XD_W-1:0] d, input logic pinned,
                         input logic [XD_W-1:0] w_data, input logic [ST_W-1:0] w_st,
                         input logic w_qe, input logic w_sf);
    req_row_t row;
    row.op          = op;
    row.qi          = qi;
    row.data        = d;
    row.pinned      = pinned;
    row.want.data   = w_data;
    row.want.status = w_st;
    row.want.qe     = w_qe;
    row.want.sf     = w_sf;
    directed_rows.push_back(row);
  endtask

  // called at a rising edge; returns at the edge the request is taken
  task automatic send_req(input logic [OP_W-1:0] op, input logic [QI_W-1:0] qi,
                          input logic [XD_W-1:0] d, input logic pinned,
                          input result_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.queue_index <= qi;
    in_if.data_in     <= d;
    pin_flag          <= pinned;
    pin_want          <= want;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               awaited_results.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin : accept_mon
    result_t r;
    if (rst_ni && in_if.valid && in_if.ready) begin
      r = queue_store_update(in_if.operation, in_if.queue_index, in_if.data_in);
      if (r.status == ST_FULL) n_full++;
      if (r.status == ST_EMPTY) n_empty++;
      awaited_results.push_back(pin_flag ? pin_want : r);
    end
  end

  always @(posedge clk_i) begin : result_mon
    result_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_checked++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing awaited, data_out %h status %0d",
                                  out_if.data_out, out_if.status));
      end else begin
        e = awaited_results.pop_front();
        if (out_if.data_out !== e.data)
          report_mismatch($sformatf("result %0d data_out %h, want %h",
                                    n_checked, out_if.data_out, e.data));
        if (out_if.status !== e.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    n_checked, out_if.status, e.status));
        if (out_if.queue_now_empty !== e.qe)
          report_mismatch($sformatf("result %0d queue_now_empty %b, want %b",
                                    n_checked, out_if.queue_now_empty, e.qe));
        if (out_if.store_now_full !== e.sf)
          report_mismatch($sformatf("result %0d store_now_full %b, want %b",
                                    n_checked, out_if.store_now_full, e.sf));
      end
    end
  end

  // receiver: runs of always-ready, a rotating stall pattern, or sparse ready
  initial begin : receiver
    int          mode;
    int          len;
    logic [15:0] pattern;
    out_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      mode    = $urandom_range(2);
      len     = $urandom_range(150, 10);
      pattern = 16'($urandom) | 16'h0001;
      repeat (len) begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: begin
            out_if.ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
          end
          default: out_if.ready <= ($urandom_range(3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [OP_W-1:0] op;
    logic [QI_W-1:0] qi;
    logic [XD_W-1:0] d;
    int              n;
    int              seg_len;
    int              mode;
    int              focus;
    int              pick;
    int              t_enq;
    int              t_deq;
    int              t_peek;

    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.operation   = OP_ENQ;
    in_if.queue_index = '0;
    in_if.data_in     = '0;
    pin_flag          = 1'b0;
    pin_want          = '0;
    burst_left        = 0;
    n_sent            = 0;
    n_checked         = 0;
    n_full            = 0;
    n_empty           = 0;
    n_errors          = 0;
    cycles            = 0;
    reset_store();

    // empty queues, ignored opcode, extremes, fill to full, drop, then one dequeue and a peek
    add_row(OP_PEEK,   2'd2, 32'h1234_5678, 1'b1, '0, ST_EMPTY, 1'b1, 1'b0);
    add_row(OP_DEQ,    2'd1, 32'h0,         1'b1, '0, ST_EMPTY, 1'b1, 1'b0);
    add_row(OP_UNUSED, 2'd0, 32'hdead_beef, 1'b1, '0, ST_DONE,  1'b1, 1'b0);
    add_row(OP_ENQ,    2'd0, 32'h8000_0000, 1'b1, '0, ST_DONE,  1'b0, 1'b0);
    add_row(OP_PEEK,   2'd0, 32'h0,         1'b1, 32'h8000_0000, ST_DONE, 1'b0, 1'b0);
    add_row(OP_ENQ,    2'd3, 32'h7fff_ffff, 1'b1, '0, ST_DONE,  1'b0, 1'b0);
    add_row(OP_DEQ,    2'd3, 32'h0,         1'b1, 32'h7fff_ffff, ST_DONE, 1'b1, 1'b0);
    add_row(OP_ENQ,    2'd3, 32'hffff_ffff, 1'b1, '0, ST_DONE,  1'b0, 1'b0);
    add_row(OP_ENQ,    2'd3, 32'h0000_0000, 1'b1, '0, ST_DONE,  1'b0, 1'b0);
    for (int i = 0; i < CAPACITY - 3; i++)
      add_row(OP_ENQ, QI_W'(i % NUM_QUEUES), $urandom, 1'b0, '0, ST_DONE, 1'b0, 1'b0);
    add_row(OP_ENQ,    2'd1, 32'h5a5a_a5a5, 1'b1, '0, ST_FULL,  1'b0, 1'b1);
    add_row(OP_DEQ,    2'd3, 32'h0,         1'b1, 32'hffff_ffff, ST_DONE, 1'b0, 1'b0);
    add_row(OP_PEEK,   2'd0, 32'h0,         1'b0, '0, ST_DONE,  1'b0, 1'b0);
    n_directed = directed_rows.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_req(directed_rows[i].op, directed_rows[i].qi, directed_rows[i].data,
               directed_rows[i].pinned, directed_rows[i].want);

    // segments lean towards filling, draining or a mix, often on one queue
    n = 0;
    while (n < RANDOM_ITEMS) begin
      seg_len = $urandom_range(120, 20);
      mode    = $urandom_range(2);
      focus   = ($urandom_range(1) == 0) ? int'($urandom_range(NUM_QUEUES - 1)) : -1;
      case (mode)
        0: begin
          t_enq  = 75;
          t_deq  = 90;
          t_peek = 98;
        end
        1: begin
          t_enq  = 15;
          t_deq  = 85;
          t_peek = 98;
        end
        default: begin
          t_enq  = 45;
          t_deq  = 80;
          t_peek = 97;
        end
      endcase
      for (int k = 0; k < seg_len && n < RANDOM_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (pick < t_enq) op = OP_ENQ;
        else if (pick < t_deq) op = OP_DEQ;
        else if (pick < t_peek) op = OP_PEEK;
        else op = OP_UNUSED;
        if (focus >= 0 && $urandom_range(4) != 0) qi = QI_W'(focus);
        else qi = QI_W'($urandom_range(NUM_QUEUES - 1));
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(4))
            0: d = '0;
            1: d = '1;
            2: d = 32'h8000_0000;
            3: d = 32'h7fff_ffff;
            default: d = 32'h0000_0001;
          endcase
        end else begin
          d = $urandom;
        end
        send_req(op, qi, d, 1'b0, '0);
        if (op != OP_UNUSED) n++;
      end
    end
    in_if.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

    $display("%0d requests sent (%0d directed), %0d results checked, %0d mismatches",
             n_sent, n_directed, n_checked, n_errors);
    $display("full-store drops %0d, empty-queue answers %0d, peak occupancy %0d/%0d",
             n_full, n_empty, peak_used, CAPACITY);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/kqs_pkg.sv
hw/rtl/kqs_in_if.sv
hw/rtl/kqs_out_if.sv
hw/rtl/kqs_ram.sv
hw/rtl/kqs_link_mem.sv
hw/rtl/k_queues_shared_store.sv
sim/k_queues_shared_store_tb.sv
